FILE: rtl/fcld_pkg.sv
// Shared types, constants and fixed-point helpers for the flow closed-loop decision unit.
package fcld_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FIELD_W     = 32;
    localparam int CNT_W       = (COUNT_WIDTH < FIELD_W) ? COUNT_WIDTH : FIELD_W;
    localparam int VAL_W       = 32;
    localparam int PROB_W      = FRAC_BITS + 1;
    localparam int SUM_W       = VAL_W + 1;
    localparam int THR_W       = PROB_W + 7;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [VAL_W-1:0] FX_ONE       = VAL_W'(64'd1 << FRAC_BITS);
    localparam logic [VAL_W-1:0] SAT_VAL      = '1;
    localparam logic [THR_W-1:0] CLOSED_LIMIT = THR_W'(64'd99 << FRAC_BITS);
    localparam logic [THR_W-1:0] OPEN_LIMIT   = THR_W'(64'd1 << FRAC_BITS);
    localparam logic [THR_W-1:0] PERCENT      = THR_W'(100);

    typedef enum logic [1:0] {
        DEC_NONE   = 2'd0,
        DEC_CLOSED = 2'd1,
        DEC_OPEN   = 2'd2,
        DEC_DUP    = 2'd3
    } decision_t;

    typedef enum logic [0:0] {
        REG_RETX_MISS = 1'b0,
        REG_MAX_DUP   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [FIELD_W-1:0] data_count;
        logic [FIELD_W-1:0] dup_count;
        logic [FIELD_W-1:0] retx_count;
        logic [FIELD_W-1:0] non_retx_count;
    } in_item_t;

    typedef struct packed {
        decision_t         decision;
        logic [PROB_W-1:0] closed_pow;
        logic [VAL_W-1:0]  p_open;
        logic [PROB_W-1:0] weight;
        logic [VAL_W-1:0]  ratio;
    } out_item_t;

    typedef struct packed {
        logic             data_zero;
        logic [CNT_W-1:0] retx;
        logic [CNT_W-1:0] nretx;
    } side_t;

    typedef struct packed {
        logic              data_zero;
        logic              exceed;
        logic [VAL_W-1:0]  ratio;
        logic [PROB_W-1:0] closed_pow;
        logic [VAL_W-1:0]  p_open;
    } pow_res_t;

    function automatic logic [VAL_W-1:0] fx_mul(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        logic [2*VAL_W-1:0] prod;
        logic [2*VAL_W-1:0] shifted;
        prod    = (2*VAL_W)'(a) * (2*VAL_W)'(b);
        shifted = prod >> FRAC_BITS;
        return (|shifted[2*VAL_W-1:VAL_W]) ? SAT_VAL : shifted[VAL_W-1:0];
    endfunction

endpackage

FILE: rtl/fcld_ratio_div.sv
// Pipelined duplicate-ratio divider, one quotient bit per stage, with saturation.
module fcld_ratio_div import fcld_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  in_item_t         in_item,
    output logic             out_valid,
    output logic [VAL_W-1:0] ratio,
    output side_t            out_side
);

    localparam int STAGES = VAL_W;

    logic             valid_reg [0:STAGES];
    logic [CNT_W-1:0] den_reg   [0:STAGES];
    logic [CNT_W-1:0] rem_reg   [0:STAGES];
    logic [VAL_W-1:0] num_reg   [0:STAGES];
    logic [VAL_W-1:0] quo_reg   [0:STAGES];
    logic             sat_reg   [0:STAGES];
    side_t            side_reg  [0:STAGES];

    logic [CNT_W-1:0] data_in;
    logic [CNT_W-1:0] dup_raw;
    logic [CNT_W-1:0] dup_in;
    logic [CNT_W-1:0] rem_init;
    logic [VAL_W-1:0] num_init;
    logic             sat_init;
    side_t            side_init;

    always_comb
    begin
        data_in   = in_item.data_count[CNT_W-1:0];
        dup_raw   = in_item.dup_count[CNT_W-1:0];
        dup_in    = (dup_raw == '0) ? CNT_W'(1) : dup_raw;
        rem_init  = dup_in >> (VAL_W - FRAC_BITS);
        sat_init  = (rem_init >= data_in);
        num_init  = VAL_W'({dup_in, {FRAC_BITS{1'b0}}});
        side_init.data_zero = (data_in == '0);
        side_init.retx      = in_item.retx_count[CNT_W-1:0];
        side_init.nretx     = in_item.non_retx_count[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= data_in;
            rem_reg[0]  <= rem_init;
            num_reg[0]  <= num_init;
            quo_reg[0]  <= '0;
            sat_reg[0]  <= sat_init;
            side_reg[0] <= side_init;
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [CNT_W:0] trial;
        logic           take;

        assign trial = {rem_reg[k], num_reg[k][VAL_W-1]};
        assign take  = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k+1]  <= den_reg[k];
                rem_reg[k+1]  <= take ? CNT_W'(trial - {1'b0, den_reg[k]})
                                      : trial[CNT_W-1:0];
                num_reg[k+1]  <= num_reg[k] << 1;
                quo_reg[k+1]  <= {quo_reg[k][VAL_W-2:0], take};
                sat_reg[k+1]  <= sat_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign ratio     = sat_reg[STAGES] ? SAT_VAL : quo_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

FILE: rtl/fcld_pow.sv
// Pipelined square-and-multiply for both probabilities, one exponent bit per stage.
module fcld_pow import fcld_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [VAL_W-1:0]  ratio,
    input  side_t             in_side,
    input  logic [PROB_W-1:0] retx_miss,
    input  logic [VAL_W-1:0]  max_dup,
    output logic              out_valid,
    output pow_res_t          out_res
);

    localparam int STAGES = CNT_W;

    logic             valid_reg  [0:STAGES];
    logic             zero_reg   [0:STAGES];
    logic             exceed_reg [0:STAGES];
    logic [VAL_W-1:0] ratio_reg  [0:STAGES];
    logic [VAL_W-1:0] base_c_reg [0:STAGES];
    logic [VAL_W-1:0] acc_c_reg  [0:STAGES];
    logic [CNT_W-1:0] exp_c_reg  [0:STAGES];
    logic [VAL_W-1:0] base_o_reg [0:STAGES];
    logic [VAL_W-1:0] acc_o_reg  [0:STAGES];
    logic [CNT_W-1:0] exp_o_reg  [0:STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0]   <= in_side.data_zero;
            exceed_reg[0] <= (max_dup != '0) && (ratio > max_dup);
            ratio_reg[0]  <= ratio;
            base_c_reg[0] <= VAL_W'(retx_miss);
            acc_c_reg[0]  <= FX_ONE;
            exp_c_reg[0]  <= in_side.nretx;
            base_o_reg[0] <= ratio;
            acc_o_reg[0]  <= FX_ONE;
            exp_o_reg[0]  <= in_side.retx;
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[k+1]   <= zero_reg[k];
                exceed_reg[k+1] <= exceed_reg[k];
                ratio_reg[k+1]  <= ratio_reg[k];
                acc_c_reg[k+1]  <= exp_c_reg[k][0] ? fx_mul(acc_c_reg[k], base_c_reg[k])
                                                   : acc_c_reg[k];
                base_c_reg[k+1] <= fx_mul(base_c_reg[k], base_c_reg[k]);
                exp_c_reg[k+1]  <= exp_c_reg[k] >> 1;
                acc_o_reg[k+1]  <= exp_o_reg[k][0] ? fx_mul(acc_o_reg[k], base_o_reg[k])
                                                   : acc_o_reg[k];
                base_o_reg[k+1] <= fx_mul(base_o_reg[k], base_o_reg[k]);
                exp_o_reg[k+1]  <= exp_o_reg[k] >> 1;
            end
        end
    end

    assign out_valid          = valid_reg[STAGES];
    assign out_res.data_zero  = zero_reg[STAGES];
    assign out_res.exceed     = exceed_reg[STAGES];
    assign out_res.ratio      = ratio_reg[STAGES];
    assign out_res.closed_pow = acc_c_reg[STAGES][PROB_W-1:0];
    assign out_res.p_open     = acc_o_reg[STAGES];

endmodule

FILE: rtl/fcld_weight.sv
// Pipelined closed-weight divider and final classification stage.
module fcld_weight import fcld_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  pow_res_t  in_res,
    output logic      out_valid,
    output out_item_t out_item
);

    localparam int QW = PROB_W;
    localparam int NW = PROB_W + FRAC_BITS;

    logic             valid_reg [0:QW];
    pow_res_t         res_reg   [0:QW];
    logic [SUM_W-1:0] sum_reg   [0:QW];
    logic [SUM_W-1:0] rem_reg   [0:QW];
    logic [QW-1:0]    num_reg   [0:QW];
    logic [QW-1:0]    quo_reg   [0:QW];
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic [NW-1:0]    num_full;
    logic [SUM_W-1:0] sum_in;

    always_comb
    begin
        num_full = {in_res.closed_pow, {FRAC_BITS{1'b0}}};
        sum_in   = SUM_W'(in_res.closed_pow) + SUM_W'(in_res.p_open);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg[0] <= in_res;
            sum_reg[0] <= sum_in;
            rem_reg[0] <= SUM_W'(num_full[NW-1:QW]);
            num_reg[0] <= num_full[QW-1:0];
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [SUM_W:0] trial;
        logic           take;

        assign trial = {rem_reg[k], num_reg[k][QW-1]};
        assign take  = (trial >= {1'b0, sum_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg[k+1] <= res_reg[k];
                sum_reg[k+1] <= sum_reg[k];
                rem_reg[k+1] <= take ? SUM_W'(trial - {1'b0, sum_reg[k]})
                                     : trial[SUM_W-1:0];
                num_reg[k+1] <= num_reg[k] << 1;
                quo_reg[k+1] <= {quo_reg[k][QW-2:0], take};
            end
        end
    end

    logic [PROB_W-1:0] w;
    logic [THR_W-1:0]  w100;
    pow_res_t          fin;
    out_item_t         item_next;

    always_comb
    begin
        fin  = res_reg[QW];
        w    = (sum_reg[QW] == '0) ? '0 : quo_reg[QW];
        w100 = THR_W'(w) * PERCENT;
        item_next = '0;
        if (fin.data_zero)
        begin
            item_next = '0;
        end
        else if (fin.exceed)
        begin
            item_next.decision = DEC_DUP;
            item_next.p_open   = FX_ONE;
            item_next.ratio    = fin.ratio;
        end
        else
        begin
            item_next.closed_pow = fin.closed_pow;
            item_next.p_open     = fin.p_open;
            item_next.weight     = w;
            item_next.ratio      = fin.ratio;
            if (w100 > CLOSED_LIMIT)
            begin
                item_next.decision = DEC_CLOSED;
            end
            else if (w100 < OPEN_LIMIT)
            begin
                item_next.decision = DEC_OPEN;
            end
            else
            begin
                item_next.decision = DEC_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item_reg <= item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: rtl/flow_closed_loop_decision_unit.sv
// Top level: configuration registers, decision pipeline and output skid stage.
// Pipeline from item acceptance to result valid: 32 ratio divider stages, 32 square-and-multiply
// stages, 17 weight divider stages, prep/decision/output registers.
// Throughput: one item per cycle; the global pipeline advance is held only while the
// two-entry output skid is full.
// Reset: rst_n clears all valid bits and both configuration registers to zero; no clearing pass.
module flow_closed_loop_decision_unit import fcld_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  in_item_t          item,
    output logic              result_valid,
    input  logic              result_stall,
    output out_item_t         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [PROB_W-1:0] retx_miss_reg;
    logic [VAL_W-1:0]  max_dup_reg;
    logic [PROB_W-1:0] miss_clamped;
    reg_index_t        reg_sel;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retx_miss_reg <= '0;
            max_dup_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_RETX_MISS: retx_miss_reg <= pwdata[PROB_W-1:0];
                REG_MAX_DUP:   max_dup_reg   <= pwdata[VAL_W-1:0];
                default:       retx_miss_reg <= retx_miss_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_RETX_MISS: prdata = DATA_W'(retx_miss_reg);
            REG_MAX_DUP:   prdata = DATA_W'(max_dup_reg);
            default:       prdata = '0;
        endcase
    end

    assign miss_clamped = (retx_miss_reg > PROB_W'(FX_ONE)) ? PROB_W'(FX_ONE) : retx_miss_reg;

    logic             en;
    logic             div_valid;
    logic [VAL_W-1:0] div_ratio;
    side_t            div_side;
    logic             pow_valid;
    pow_res_t         pow_res;
    logic             fin_valid;
    out_item_t        fin_item;

    fcld_ratio_div u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .in_item   (item),
        .out_valid (div_valid),
        .ratio     (div_ratio),
        .out_side  (div_side)
    );

    fcld_pow u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .ratio     (div_ratio),
        .in_side   (div_side),
        .retx_miss (miss_clamped),
        .max_dup   (max_dup_reg),
        .out_valid (pow_valid),
        .out_res   (pow_res)
    );

    fcld_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pow_valid),
        .in_res    (pow_res),
        .out_valid (fin_valid),
        .out_item  (fin_item)
    );

    logic      main_v_reg;
    logic      spare_v_reg;
    out_item_t main_reg;
    out_item_t spare_reg;
    logic      push;
    logic      pop;

    assign en         = !spare_v_reg;
    assign item_stall = spare_v_reg;
    assign push       = en && fin_valid;
    assign pop        = main_v_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg  <= 1'b0;
            spare_v_reg <= 1'b0;
        end
        else if (spare_v_reg)
        begin
            if (pop)
            begin
                spare_v_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            main_v_reg <= 1'b1;
            if (main_v_reg && !pop)
            begin
                spare_v_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (spare_v_reg)
        begin
            if (pop)
            begin
                main_reg <= spare_reg;
            end
        end
        else if (push)
        begin
            if (!main_v_reg || pop)
            begin
                main_reg <= fin_item;
            end
            else
            begin
                spare_reg <= fin_item;
            end
        end
    end

    assign result_valid = main_v_reg;
    assign result       = main_reg;

    a_spare_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        spare_v_reg |-> main_v_reg)
        else $error("skid spare entry held without main entry");

    a_spare_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(spare_v_reg) |-> $past(result_stall))
        else $error("skid spare filled without output stall");

    a_dup_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.decision == DEC_DUP |->
            result.closed_pow == '0 && result.weight == '0 && result.p_open == FX_ONE)
        else $error("duplicate-exceeded result carries stray values");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.weight <= PROB_W'(FX_ONE))
        else $error("closed weight above one");

    a_closed_weight: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.decision == DEC_CLOSED |->
            THR_W'(result.weight) * PERCENT > CLOSED_LIMIT)
        else $error("closed-loop decision with weight below limit");

endmodule
